/* design/chs_pkg.sv */
// ----------------------------------------------------------------------------
// chs_pkg
// Shared sizes, codes and controller/datapath types of the coalesced hash set.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int unsigned SLOTS    = 64;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
  localparam int unsigned STAT_W   = 3;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_PROBE,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // latch item, read home slot
    logic    step_link;   // follow link of current slot
    logic    step_probe;  // advance to next slot cyclically
    logic    mark_tail;   // remember chain end, restart step count
    logic    store;       // write key into current slot
    logic    link_tail;   // link chain end to current slot
    logic    set_res;     // capture result
    status_e res_status;
    logic    res_use_cur; // result slot is current slot, else zero
    logic    push_out;    // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic action;
    logic filled;
    logic linked;
    logic key_match;
    logic table_full;
    logic steps_done;
    logic out_free;
  } stat_t;

endpackage

/* design/chs_if.sv */
// ----------------------------------------------------------------------------
// chs_if
// Valid/ready channels carrying items into and results out of the hash set.
// ----------------------------------------------------------------------------
interface chs_in_if;
  import chs_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [KEY_BITS-1:0] key;
  logic [SLOT_W-1:0]   home_slot;

  modport source (output valid, action, key, home_slot, input ready);
  modport sink   (input valid, action, key, home_slot, output ready);
endinterface

interface chs_out_if;
  import chs_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  element_count;

  modport source (output valid, status, slot, element_count, input ready);
  modport sink   (input valid, status, slot, element_count, output ready);
endinterface

/* design/coalesced_hash_set.sv */
// ----------------------------------------------------------------------------
// coalesced_hash_set
// Key set kept by coalesced hashing over a slot table, insert and query.
// ----------------------------------------------------------------------------
// One item is worked at a time. After the transfer the block checks the home
// slot, follows links along the chain for W steps (one slot per cycle, paced by
// the registered read port of the key/link memory) and then loads the output
// register. An insert whose chain end is occupied adds P steps of forward
// probing for a free slot (one slot per cycle over the filled bits) and then
// claims it. W and P are each at most SLOTS. The load of the output register
// waits while the previous result is still held there unaccepted; the next
// item is taken while a result waits. The table is empty after reset with no
// clearing pass.
module coalesced_hash_set (
  input  logic      clk_i,
  input  logic      rst_ni,
  chs_in_if.sink    in_i,
  chs_out_if.source out_o
);
  import chs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  chs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  chs_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_action_i    (in_i.action),
    .in_key_i       (in_i.key),
    .in_home_slot_i (in_i.home_slot),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_status_o   (out_o.status),
    .out_slot_o     (out_o.slot),
    .out_count_o    (out_o.element_count)
  );

endmodule

/* design/chs_ctrl.sv */
// ----------------------------------------------------------------------------
// chs_ctrl
// Sequencer for chain walk, linear probe and result hand-off.
// ----------------------------------------------------------------------------
module chs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  chs_pkg::stat_t stat_i,
  output chs_pkg::cmd_t  cmd_o
);
  import chs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.res_status = ST_NOT_FOUND;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WALK;
        end
      end

      S_WALK: begin
        if (stat_i.action == ACT_QUERY) begin
          if (stat_i.steps_done || !stat_i.filled) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ST_NOT_FOUND;
            state_d          = S_DONE;
          end else if (stat_i.key_match) begin
            cmd_o.set_res     = 1'b1;
            cmd_o.res_status  = ST_FOUND;
            cmd_o.res_use_cur = 1'b1;
            state_d           = S_DONE;
          end else if (!stat_i.linked) begin
            cmd_o.set_res    = 1'b1;
            cmd_o.res_status = ST_NOT_FOUND;
            state_d          = S_DONE;
          end else begin
            cmd_o.step_link = 1'b1;
          end
        end else if (stat_i.table_full) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d          = S_DONE;
        end else if (!stat_i.steps_done && stat_i.filled && stat_i.linked) begin
          if (stat_i.key_match) begin
            cmd_o.set_res     = 1'b1;
            cmd_o.res_status  = ST_DUPLICATE;
            cmd_o.res_use_cur = 1'b1;
            state_d           = S_DONE;
          end else begin
            cmd_o.step_link = 1'b1;
          end
        end else if (stat_i.filled) begin
          // chain end is occupied: duplicate, or go find a free slot
          if (stat_i.key_match) begin
            cmd_o.set_res     = 1'b1;
            cmd_o.res_status  = ST_DUPLICATE;
            cmd_o.res_use_cur = 1'b1;
            state_d           = S_DONE;
          end else begin
            cmd_o.mark_tail = 1'b1;
            state_d         = S_PROBE;
          end
        end else begin
          cmd_o.store       = 1'b1;
          cmd_o.set_res     = 1'b1;
          cmd_o.res_status  = ST_INSERTED;
          cmd_o.res_use_cur = 1'b1;
          state_d           = S_DONE;
        end
      end

      S_PROBE: begin
        if (!stat_i.steps_done && stat_i.filled) begin
          cmd_o.step_probe = 1'b1;
        end else if (stat_i.filled) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_FULL;
          state_d          = S_DONE;
        end else begin
          cmd_o.link_tail   = 1'b1;
          cmd_o.store       = 1'b1;
          cmd_o.set_res     = 1'b1;
          cmd_o.res_status  = ST_INSERTED;
          cmd_o.res_use_cur = 1'b1;
          state_d           = S_DONE;
        end
      end

      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.push_out = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* design/chs_dpath.sv */
// ----------------------------------------------------------------------------
// chs_dpath
// Slot storage, walk pointer, step counter, result and output registers.
// ----------------------------------------------------------------------------
module chs_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  chs_pkg::cmd_t                  cmd_i,
  output chs_pkg::stat_t                 stat_o,
  input  logic                           in_action_i,
  input  logic [chs_pkg::KEY_BITS-1:0]   in_key_i,
  input  logic [chs_pkg::SLOT_W-1:0]     in_home_slot_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [chs_pkg::STAT_W-1:0]     out_status_o,
  output logic [chs_pkg::SLOT_W-1:0]     out_slot_o,
  output logic [chs_pkg::CNT_W-1:0]      out_count_o
);
  import chs_pkg::*;

  // slot memories, one registered read port each
  logic [KEY_BITS-1:0] key_mem  [SLOTS];
  logic [SLOT_W-1:0]   link_mem [SLOTS];
  logic [KEY_BITS-1:0] key_rd_q;
  logic [SLOT_W-1:0]   link_rd_q;
  logic [SLOT_W-1:0]   rd_addr;

  logic [SLOTS-1:0]    filled_q, linked_q;
  logic [CNT_W-1:0]    count_q;

  logic                action_q;
  logic [KEY_BITS-1:0] key_q;
  logic [SLOT_W-1:0]   cur_q, cur_d, tail_q;
  logic [CNT_W-1:0]    steps_q;

  status_e             res_status_q;
  logic [SLOT_W-1:0]   res_slot_q;

  logic                out_valid_q;
  logic [STAT_W-1:0]   out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [CNT_W-1:0]    out_count_q;

  always_comb begin
    cur_d = cur_q;
    if (cmd_i.load) begin
      cur_d = in_home_slot_i;
    end else if (cmd_i.step_link) begin
      cur_d = link_rd_q;
    end else if (cmd_i.step_probe) begin
      cur_d = (cur_q == SLOT_W'(SLOTS - 1)) ? '0 : cur_q + 1'b1;
    end
    rd_addr = cur_d;
  end

  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[rd_addr];
    link_rd_q <= link_mem[rd_addr];
    if (cmd_i.store) begin
      key_mem[cur_q] <= key_q;
    end
    if (cmd_i.link_tail) begin
      link_mem[tail_q] <= cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      linked_q <= '0;
      count_q  <= '0;
    end else begin
      if (cmd_i.store) begin
        filled_q[cur_q] <= 1'b1;
        linked_q[cur_q] <= 1'b0;
        count_q         <= count_q + 1'b1;
      end
      if (cmd_i.link_tail) begin
        linked_q[tail_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.load) begin
      action_q <= in_action_i;
      key_q    <= in_key_i;
    end
    if (cmd_i.mark_tail) begin
      tail_q <= cur_q;
    end
    if (cmd_i.load || cmd_i.mark_tail) begin
      steps_q <= '0;
    end else if (cmd_i.step_link || cmd_i.step_probe) begin
      steps_q <= steps_q + 1'b1;
    end
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_slot_q   <= cmd_i.res_use_cur ? cur_q : '0;
    end
  end

  // output register: result waits here while the next item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_out) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_count_q  <= count_q;
    end
  end

  assign stat_o.action     = action_q;
  assign stat_o.filled     = filled_q[cur_q];
  assign stat_o.linked     = linked_q[cur_q];
  assign stat_o.key_match  = (key_rd_q == key_q);
  assign stat_o.table_full = (count_q == CNT_W'(SLOTS));
  assign stat_o.steps_done = (steps_q == CNT_W'(SLOTS));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_count_o  = out_count_q;

endmodule

/* design/chs_checker.sv */
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks of the hash set, bound to the top level.
// ----------------------------------------------------------------------------
module chs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [chs_pkg::STAT_W-1:0]    status_i,
  input logic [chs_pkg::SLOT_W-1:0]    slot_i,
  input logic [chs_pkg::CNT_W-1:0]     count_i
);
  import chs_pkg::*;

  // one item in flight: no transfer right after another
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(status_i) && $stable(slot_i) && $stable(count_i))
    else $error("stalled result changed");

  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_i <= CNT_W'(SLOTS) && status_i <= STAT_W'(ST_NOT_FOUND))
    else $error("result field out of range");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_W'(ST_FULL) |-> slot_i == '0 && count_i == CNT_W'(SLOTS))
    else $error("table full reported on a table with room");

  a_inserted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_W'(ST_INSERTED) |-> count_i != '0)
    else $error("insert left the table empty");

endmodule

bind coalesced_hash_set chs_checker u_chs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .slot_i      (out_o.slot),
  .count_i     (out_o.element_count)
);

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the coalesced hash set. A mirror of the slot table
// predicts every result, and each result is checked in order as it leaves the
// block. A directed prologue covers the empty table, chain building,
// duplicates, wrap-around probing and coalesced chains. Random traffic follows
// and fills the table, so later items run into full-table inserts and long
// walks. Items go in as bursts with gaps, and the result side stalls in
// shifting patterns.
// ----------------------------------------------------------------------------
module tb;
  import chs_pkg::*;

  typedef struct {
    logic                action;
    logic [KEY_BITS-1:0] key;
    logic [SLOT_W-1:0]   home;
  } item_t;

  typedef struct {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } outcome_t;

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_COIN,
    SINK_SLUGGISH,
    SINK_PERIODIC
  } sink_mode_e;

  // Mirror of the slot table; predicts the outcome of each transfer in.
  class hash_set_mirror;
    bit                  filled[SLOTS];
    logic [KEY_BITS-1:0] keys[SLOTS];
    int unsigned         links[SLOTS];
    bit                  linked[SLOTS];
    int unsigned         held;
    outcome_t            awaited_results[$];
    int unsigned         mismatches;
    int unsigned         shown;

    function new();
      foreach (filled[i]) begin
        filled[i] = 1'b0;
        keys[i]   = '0;
        links[i]  = 0;
        linked[i] = 1'b0;
      end
      held       = 0;
      mismatches = 0;
      shown      = 0;
    endfunction

    function outcome_t work_out(item_t it);
      outcome_t    res;
      int unsigned cur;
      int unsigned tail;
      int unsigned n;
      bit          done;
      cur        = it.home % SLOTS;
      res.status = ST_NOT_FOUND;
      res.slot   = '0;
      done       = 1'b0;
      n          = 0;
      if (it.action == ACT_QUERY) begin
        if (held != 0) begin
          while (!done && n < SLOTS && filled[cur]) begin
            if (keys[cur] == it.key) begin
              res.status = ST_FOUND;
              res.slot   = SLOT_W'(cur);
              done       = 1'b1;
            end else if (!linked[cur]) begin
              done = 1'b1;
            end else begin
              cur = links[cur];
              n++;
            end
          end
        end
      end else if (held >= SLOTS) begin
        res.status = ST_FULL;
      end else begin
        // walk to the chain end, stop on a matching key
        while (!done && n < SLOTS && filled[cur] && linked[cur]) begin
          if (keys[cur] == it.key) begin
            res.status = ST_DUPLICATE;
            res.slot   = SLOT_W'(cur);
            done       = 1'b1;
          end else begin
            cur = links[cur];
            n++;
          end
        end
        if (!done && filled[cur]) begin
          tail = cur;
          if (keys[cur] == it.key) begin
            res.status = ST_DUPLICATE;
            res.slot   = SLOT_W'(cur);
            done       = 1'b1;
          end else begin
            n = 0;
            while (n < SLOTS && filled[cur]) begin
              cur = (cur + 1) % SLOTS;
              n++;
            end
            if (filled[cur]) begin
              res.status = ST_FULL;
              done       = 1'b1;
            end else begin
              links[tail]  = cur;
              linked[tail] = 1'b1;
            end
          end
        end
        if (!done) begin
          filled[cur] = 1'b1;
          keys[cur]   = it.key;
          links[cur]  = 0;
          linked[cur] = 1'b0;
          held++;
          res.status = ST_INSERTED;
          res.slot   = SLOT_W'(cur);
        end
      end
      res.count = held[CNT_W-1:0];
      return res;
    endfunction

    function void note_item(item_t it);
      awaited_results.push_back(work_out(it));
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [SLOT_W-1:0] slot,
                               logic [CNT_W-1:0] count);
      outcome_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (shown < 200) begin
          shown++;
          $display("%0t: unexpected result, expected none, %s %0d slot %0d count %0d",
                   $time, "actual status", status, slot, count);
        end
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.status || slot !== want.slot || count !== want.count) begin
          mismatches++;
          if (shown < 200) begin
            shown++;
            $display("%0t: mismatch, expected status %0d slot %0d count %0d, %s",
                     $time, want.status, want.slot, want.count, "actual");
            $display("%0t:   actual status %0d slot %0d count %0d",
                     $time, status, slot, count);
          end
        end
      end
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  chs_in_if  in_if();
  chs_out_if out_if();

  coalesced_hash_set i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  hash_set_mirror board = new();
  item_t          known_keys[$];
  int unsigned    burst_left = 0;
  logic [SLOT_W-1:0] cluster_base = '0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL coalesced_hash_set");
    $finish;
  end

  // Hold the payload between bursts so that every input stays known.
  task automatic idle_gap(input int unsigned cycles);
    in_if.valid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Drive one item at the falling edge and hold it until the transfer.
  task automatic transfer_item(input item_t it);
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = 60;
      end else begin
        idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8));
        burst_left = $urandom_range(1, 12);
      end
    end
    burst_left--;
    in_if.valid     = 1'b1;
    in_if.action    = it.action;
    in_if.key       = it.key;
    in_if.home_slot = it.home;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_item(it);
    if (it.action == ACT_INSERT) known_keys.push_back(it);
    @(negedge clk_i);
  endtask

  function automatic item_t make_item(logic action, logic [KEY_BITS-1:0] key,
                                      logic [SLOT_W-1:0] home);
    item_t it;
    it.action = action;
    it.key    = key;
    it.home   = home;
    return it;
  endfunction

  function automatic logic [KEY_BITS-1:0] fresh_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return '0;
      1:       return '1;
      2:       return KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic item_t random_item();
    item_t       it;
    item_t       old;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (known_keys.size() != 0) old = known_keys[$urandom_range(0, known_keys.size() - 1)];
    if (r < 30 || (known_keys.size() == 0 && r < 90)) begin
      it.action = ACT_INSERT;
      it.key    = fresh_key();
      // cluster home slots to grow long chains and probes
      it.home   = $urandom_range(0, 1) ? cluster_base + SLOT_W'($urandom_range(0, 3))
                                       : SLOT_W'($urandom_range(0, SLOTS - 1));
    end else if (r < 42) begin
      it = make_item(ACT_INSERT, old.key, old.home);
    end else if (r < 48) begin
      it = make_item(ACT_INSERT, old.key, SLOT_W'($urandom_range(0, SLOTS - 1)));
    end else if (r < 80) begin
      it = make_item(ACT_QUERY, old.key, old.home);
    end else if (r < 90) begin
      it = make_item(ACT_QUERY, old.key, SLOT_W'($urandom_range(0, SLOTS - 1)));
    end else begin
      it = make_item(ACT_QUERY, fresh_key(), SLOT_W'($urandom_range(0, SLOTS - 1)));
    end
    return it;
  endfunction

  // Result side: stall in a random pattern, switched to a new random pattern when its run ends.
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned left;
    int unsigned phase;
    mode         = SINK_OPEN;
    left         = 0;
    phase        = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        left = $urandom_range(10, 80);
      end
      left--;
      phase++;
      case (mode)
        SINK_OPEN:     out_if.ready = 1'b1;
        SINK_COIN:     out_if.ready = 1'($urandom_range(0, 1));
        SINK_SLUGGISH: out_if.ready = ($urandom_range(0, 3) == 0);
        default:       out_if.ready = (phase % 5) != 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      board.check_result(out_if.status, out_if.slot, out_if.element_count);
    end
  end

  initial begin : stimulus
    int unsigned n;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.action    = ACT_INSERT;
    in_if.key       = '0;
    in_if.home_slot = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // query on the empty table
    transfer_item(make_item(ACT_QUERY,  32'h0000_0000, 6'd0));
    transfer_item(make_item(ACT_INSERT, 32'h0000_0000, 6'd0));
    // duplicate held at the home slot, which is also the chain end
    transfer_item(make_item(ACT_INSERT, 32'h0000_0000, 6'd0));
    transfer_item(make_item(ACT_INSERT, 32'hFFFF_FFFF, 6'd0));
    transfer_item(make_item(ACT_INSERT, 32'hA5A5_A5A5, 6'd0));
    // duplicate inside the chain, then at its end
    transfer_item(make_item(ACT_INSERT, 32'hFFFF_FFFF, 6'd0));
    transfer_item(make_item(ACT_INSERT, 32'hA5A5_A5A5, 6'd0));
    transfer_item(make_item(ACT_INSERT, 32'h0000_0001, 6'd63));
    // probe wraps past the last slot
    transfer_item(make_item(ACT_INSERT, 32'h0000_0002, 6'd63));
    // home slot taken by another chain: chains coalesce
    transfer_item(make_item(ACT_INSERT, 32'h0000_0003, 6'd1));
    transfer_item(make_item(ACT_QUERY,  32'h0000_0003, 6'd0));
    transfer_item(make_item(ACT_QUERY,  32'h0000_0002, 6'd63));
    transfer_item(make_item(ACT_QUERY,  32'hFFFF_FFFF, 6'd1));
    transfer_item(make_item(ACT_QUERY,  32'h1234_5678, 6'd0));
    transfer_item(make_item(ACT_QUERY,  32'h0000_0000, 6'd5));
    transfer_item(make_item(ACT_QUERY,  32'h0000_0001, 6'd3));
    transfer_item(make_item(ACT_INSERT, 32'h5A5A_5A5A, 6'd62));
    transfer_item(make_item(ACT_INSERT, 32'h8000_0000, 6'd62));
    transfer_item(make_item(ACT_QUERY,  32'h8000_0000, 6'd62));
    transfer_item(make_item(ACT_QUERY,  32'h7FFF_FFFF, 6'd62));

    for (n = 0; n < 1000; n++) begin
      if (n % 30 == 0) begin
        cluster_base = $urandom_range(0, 2) == 0 ? SLOT_W'(62)
                                                 : SLOT_W'($urandom_range(0, SLOTS - 1));
      end
      transfer_item(random_item());
    end
    in_if.valid = 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    // let any stray result show up before the verdict
    repeat (200) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("PASS coalesced_hash_set");
    end else begin
      $display("FAIL coalesced_hash_set");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/chs_pkg.sv
design/chs_if.sv
design/chs_ctrl.sv
design/chs_dpath.sv
design/coalesced_hash_set.sv
design/chs_checker.sv
dv/tb.sv
